### src/bols_pkg.sv
// Package for the bounded ordered list store.
// Holds sizes, operation and status codes, payload structs and the command struct.
// No dependencies.
package bols_pkg;

  // Number of cells in the store.
  localparam int unsigned DEPTH = 16;
  // Cell index width.
  localparam int unsigned IDX_W = $clog2(DEPTH);
  // Element count width, fixed by the entry_total field.
  localparam int unsigned CNT_W = 5;

  // Operation codes.
  localparam logic [2:0] OP_INS_FRONT = 3'd0;
  localparam logic [2:0] OP_INS_END   = 3'd1;
  localparam logic [2:0] OP_DEL_FRONT = 3'd2;
  localparam logic [2:0] OP_DEL_END   = 3'd3;
  localparam logic [2:0] OP_INS_POS   = 3'd4;
  localparam logic [2:0] OP_READ_FWD  = 3'd5;
  localparam logic [2:0] OP_READ_REV  = 3'd6;

  // Status codes.
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_BADPOS = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [31:0] item_value;
    logic [4:0]         position;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] out_value;
    logic [4:0]         entry_total;
    logic               last_of_run;
  } out_word_t;

  // Command from the controller to the datapath for the current cycle.
  typedef struct packed {
    logic             ins;
    logic             del;
    logic [IDX_W-1:0] idx;
    logic             emit;
    logic [1:0]       status;
    logic             take_cell;
    logic             last;
  } cmd_t;

endpackage

### src/bols_datapath.sv
// Datapath of the bounded ordered list store: shift cells, element count, result register.
// Depends on bols_pkg.
module bols_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bols_pkg::cmd_t              cmd_i,
  input  logic signed [31:0]          value_i,
  output logic [bols_pkg::CNT_W-1:0]  count_o,
  output logic                        strobe_o,
  output bols_pkg::out_word_t         result_o
);

  logic signed [31:0]         cell_q [bols_pkg::DEPTH];
  logic signed [31:0]         cell_d [bols_pkg::DEPTH];
  logic [bols_pkg::CNT_W-1:0] count_q, count_d;
  logic                       strobe_q;
  bols_pkg::out_word_t        result_q;
  logic signed [31:0]         sel_cell;

  assign sel_cell = cell_q[cmd_i.idx];

  // Each cell takes its own value, the input value, its left neighbor's or its right neighbor's.
  for (genvar i = 0; i < bols_pkg::DEPTH; i++) begin : g_cell
    always_comb begin
      cell_d[i] = cell_q[i];
      if (cmd_i.ins) begin
        if (bols_pkg::IDX_W'(i) == cmd_i.idx) begin
          cell_d[i] = value_i;
        end else if (i > 0) begin
          if ((bols_pkg::IDX_W'(i) > cmd_i.idx) && (bols_pkg::CNT_W'(i) <= count_q)) begin
            cell_d[i] = cell_q[(i > 0) ? i - 1 : 0];
          end
        end
      end else if (cmd_i.del) begin
        if ((i < bols_pkg::DEPTH - 1) && (bols_pkg::IDX_W'(i) >= cmd_i.idx)
            && (bols_pkg::CNT_W'(i + 1) < count_q)) begin
          cell_d[i] = cell_q[(i < bols_pkg::DEPTH - 1) ? i + 1 : i];
        end
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.ins) begin
      count_d = count_q + bols_pkg::CNT_W'(1);
    end else if (cmd_i.del) begin
      count_d = count_q - bols_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < bols_pkg::DEPTH; k++) begin
      cell_q[k] <= cell_d[k];
    end
    if (cmd_i.emit) begin
      result_q.status      <= cmd_i.status;
      result_q.out_value   <= cmd_i.take_cell ? sel_cell : 32'sd0;
      result_q.entry_total <= count_d;
      result_q.last_of_run <= cmd_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      strobe_q <= 1'b0;
    end else begin
      count_q  <= count_d;
      strobe_q <= cmd_i.emit;
    end
  end

  assign count_o  = count_q;
  assign strobe_o = strobe_q;
  assign result_o = result_q;

endmodule

### src/bols_ctrl.sv
// Controller of the bounded ordered list store: decodes operations and sequences reads.
// Depends on bols_pkg.
module bols_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  bols_pkg::in_word_t          item_i,
  input  logic [bols_pkg::CNT_W-1:0]  count_i,
  output logic                        busy_o,
  output bols_pkg::cmd_t              cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_e;

  state_e                     state_q;
  logic [bols_pkg::IDX_W-1:0] rd_idx_q;
  logic [bols_pkg::CNT_W-1:0] remain_q;
  logic                       rev_q;

  logic                       full;
  logic                       empty;
  logic                       pos_bad;
  logic                       rd_go;
  logic                       rd_rev;
  logic [bols_pkg::IDX_W-1:0] last_idx;

  assign full     = (count_i == bols_pkg::CNT_W'(bols_pkg::DEPTH));
  assign empty    = (count_i == '0);
  assign last_idx = bols_pkg::IDX_W'(count_i - bols_pkg::CNT_W'(1));
  assign pos_bad  = (item_i.position == 5'd0)
                 || ({1'b0, item_i.position} > ({1'b0, count_i} + 6'd1));

  always_comb begin
    cmd_o  = '0;
    rd_go  = 1'b0;
    rd_rev = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.emit   = 1'b1;
          cmd_o.last   = 1'b1;
          cmd_o.status = bols_pkg::ST_OK;
          unique case (item_i.opcode)
            bols_pkg::OP_INS_FRONT, bols_pkg::OP_INS_END: begin
              if (full) begin
                cmd_o.status = bols_pkg::ST_FULL;
              end else begin
                cmd_o.ins = 1'b1;
                cmd_o.idx = (item_i.opcode == bols_pkg::OP_INS_FRONT) ? '0
                          : bols_pkg::IDX_W'(count_i);
              end
            end
            bols_pkg::OP_INS_POS: begin
              if (pos_bad) begin
                cmd_o.status = bols_pkg::ST_BADPOS;
              end else if (full) begin
                cmd_o.status = bols_pkg::ST_FULL;
              end else begin
                cmd_o.ins = 1'b1;
                cmd_o.idx = bols_pkg::IDX_W'(item_i.position - 5'd1);
              end
            end
            bols_pkg::OP_DEL_FRONT, bols_pkg::OP_DEL_END: begin
              if (empty) begin
                cmd_o.status = bols_pkg::ST_EMPTY;
              end else begin
                cmd_o.del       = 1'b1;
                cmd_o.take_cell = 1'b1;
                cmd_o.idx = (item_i.opcode == bols_pkg::OP_DEL_FRONT) ? '0 : last_idx;
              end
            end
            bols_pkg::OP_READ_FWD, bols_pkg::OP_READ_REV: begin
              if (empty) begin
                cmd_o.status = bols_pkg::ST_EMPTY;
              end else begin
                rd_rev          = (item_i.opcode == bols_pkg::OP_READ_REV);
                cmd_o.take_cell = 1'b1;
                cmd_o.idx       = rd_rev ? last_idx : '0;
                cmd_o.last      = (count_i == bols_pkg::CNT_W'(1));
                rd_go           = !cmd_o.last;
              end
            end
            default: begin
              cmd_o.status = bols_pkg::ST_OK;
            end
          endcase
        end
      end
      S_READ: begin
        cmd_o.emit      = 1'b1;
        cmd_o.take_cell = 1'b1;
        cmd_o.status    = bols_pkg::ST_OK;
        cmd_o.idx       = rd_idx_q;
        cmd_o.last      = (remain_q == bols_pkg::CNT_W'(1));
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      rd_idx_q <= '0;
      remain_q <= '0;
      rev_q    <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (rd_go) begin
            state_q  <= S_READ;
            rev_q    <= rd_rev;
            remain_q <= count_i - bols_pkg::CNT_W'(1);
            rd_idx_q <= rd_rev ? last_idx - bols_pkg::IDX_W'(1) : bols_pkg::IDX_W'(1);
          end
        end
        S_READ: begin
          remain_q <= remain_q - bols_pkg::CNT_W'(1);
          rd_idx_q <= rev_q ? rd_idx_q - bols_pkg::IDX_W'(1)
                            : rd_idx_q + bols_pkg::IDX_W'(1);
          if (remain_q == bols_pkg::CNT_W'(1)) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy_o = (state_q == S_READ);

endmodule

### src/bounded_ordered_list_store.sv
// Top level of the bounded ordered list store.
// Instantiates bols_ctrl and bols_datapath; depends on bols_pkg.

// The block keeps an ordered list of up to 16 signed 32-bit values in a row of
// shift cells, front at cell 0. An operation word is taken at a rising clock edge
// where start_i is high and busy_o is low. For inserts, deletes and the unused
// opcode the cells shift in parallel on the accepting edge and a single result
// word appears with strobe_o in the next cycle, so while busy_o is low such
// words can be issued every cycle. A forward or reverse read of a non-empty list
// walks the cells through one read port, one element per cycle, giving one result
// word per element, the last one marked by last_of_run; busy_o is high while the
// elements after the first are read. A read of an empty list gives one word with
// status empty. Each result word is flagged by strobe_o for exactly one cycle;
// the receiver cannot stall the block and must take each word as it comes.
// Insert position checks come before the full check, and a full store rejects
// inserts without changing the list.
module bounded_ordered_list_store (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  bols_pkg::in_word_t   item_i,
  output logic                 busy_o,
  output logic                 strobe_o,
  output bols_pkg::out_word_t  result_o
);

  // Command from the controller and the element count fed back to it.
  bols_pkg::cmd_t             cmd;
  logic [bols_pkg::CNT_W-1:0] count;

  bols_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .item_i  (item_i),
    .count_i (count),
    .busy_o  (busy_o),
    .cmd_o   (cmd)
  );

  // The datapath registers each result word, so results leave from flops.
  bols_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .value_i  (item_i.item_value),
    .count_o  (count),
    .strobe_o (strobe_o),
    .result_o (result_o)
  );

endmodule
